@@ rtl/tta_pkg.sv @@
// Shared constants and types for the transpose address generator.
`default_nettype none
package tta_pkg;

   // Fixed register-map geometry
   localparam int NUM_AXES   = 4;
   localparam int RANK_W     = 3;
   localparam int PERM_W     = 2;
   localparam int ORDER_W    = 8;
   localparam int SIZE_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Parameter defaults
   localparam int DEF_MAX_RANK  = 4;
   localparam int DEF_DIM_BITS  = 16;
   localparam int DEF_ADDR_BITS = 32;

   // Register reset values
   localparam logic [RANK_W-1:0]  RANK_RESET  = 3'd1;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 8'hE4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANK       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS0_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS1_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS2_SIZE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS3_SIZE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_ORDER = 3'd5;

   // Derived configuration status, derive unit to walk
   typedef struct packed {
      logic              busy;
      logic              cfg_err;
      logic              empty;
      logic              order_keep;
      logic [RANK_W-1:0] rank;
   } tta_status_type;

endpackage
`default_nettype wire

@@ rtl/tta_derive.sv @@
// Configuration registers and serial derivation of strides, overflow and offset terms.
`default_nettype none
module tta_derive #(
   parameter int MAX_RANK  = tta_pkg::DEF_MAX_RANK,
   parameter int DIM_BITS  = tta_pkg::DEF_DIM_BITS,
   parameter int ADDR_BITS = tta_pkg::DEF_ADDR_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [tta_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tta_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [DIM_BITS-1:0]                 coord [MAX_RANK],
   output tta_pkg::tta_status_type                  status,
   output logic [DIM_BITS-1:0]                      out_dim [MAX_RANK],
   output logic [ADDR_BITS-1:0]                     src_stride [MAX_RANK],
   output logic                                     prod_we,
   output logic [$clog2(MAX_RANK)-1:0]              prod_idx,
   output logic [ADDR_BITS-1:0]                     prod_data
);
   import tta_pkg::*;

   localparam int MW    = ADDR_BITS + DIM_BITS;
   localparam int CNT_W = $clog2(DIM_BITS);
   localparam int K_W   = $clog2(MAX_RANK);
   localparam int AX_W  = $clog2(NUM_AXES);
   localparam logic [RANK_W-1:0] RANK_LIM =
      RANK_W'((MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES);
   localparam logic [MW-1:0] ADDR_POW = MW'(1) << ADDR_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_SLOAD, S_SMUL, S_PLOAD, S_PMUL
   } state_type;

   state_type             state_ff;
   logic [RANK_W-1:0]     rank_ff;
   logic [DIM_BITS-1:0]   size_ff [NUM_AXES];
   logic [ORDER_W-1:0]    order_ff;
   logic [ADDR_BITS-1:0]  in_stride_ff [NUM_AXES];
   logic [AX_W-1:0]       ax_ff;
   logic [K_W-1:0]        k_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [MW-1:0]         mcand_ff;
   logic [DIM_BITS-1:0]   mplier_ff;
   logic [MW-1:0]         acc_ff;
   logic                  ge_ff;
   logic                  ovf_ff;
   logic                  prod_we_ff;
   logic [K_W-1:0]        prod_idx_ff;
   logic [ADDR_BITS-1:0]  prod_data_ff;

   logic [PERM_W-1:0]     perm [NUM_AXES];
   logic                  rank_ok;
   logic                  perm_ok;
   logic                  empty;
   logic                  order_keep;
   logic [MW-1:0]         acc_in;
   logic                  last_bit;
   logic [DIM_BITS-1:0]   size_in;

   assign size_in = DIM_BITS'(csr_wdata[SIZE_W-1:0]);

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= RANK_RESET;
         order_ff <= ORDER_RESET;
         for (int i = 0; i < NUM_AXES; i++) begin
            size_ff[i] <= DIM_BITS'(1);
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANK:       rank_ff    <= csr_wdata[RANK_W-1:0];
            CSR_AXIS0_SIZE: size_ff[0] <= size_in;
            CSR_AXIS1_SIZE: size_ff[1] <= size_in;
            CSR_AXIS2_SIZE: size_ff[2] <= size_in;
            CSR_AXIS3_SIZE: size_ff[3] <= size_in;
            CSR_AXIS_ORDER: order_ff   <= csr_wdata[ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // Permutation, empty-tensor and order-preserving checks
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         perm[i] = order_ff[PERM_W*i +: PERM_W];
      end
      rank_ok = (rank_ff != '0) && (rank_ff <= RANK_LIM);
      perm_ok = rank_ok;
      empty   = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (RANK_W'(i) < rank_ff) begin
            if (RANK_W'(perm[i]) >= rank_ff) perm_ok = 1'b0;
            for (int m = 0; m < i; m++) begin
               if (perm[m] == perm[i]) perm_ok = 1'b0;
            end
            if (size_ff[i] == '0) empty = 1'b1;
         end
      end
      empty = empty && perm_ok;
      // non-singleton axes must appear in source order
      order_keep = perm_ok;
      for (int i = 0; i < NUM_AXES; i++) begin
         for (int j = i + 1; j < NUM_AXES; j++) begin
            if ((RANK_W'(j) < rank_ff) && (size_ff[perm[i]] != DIM_BITS'(1)) &&
                (size_ff[perm[j]] != DIM_BITS'(1)) && (perm[i] > perm[j])) begin
               order_keep = 1'b0;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_RANK; k++) begin
         out_dim[k]    = DIM_BITS'(1);
         src_stride[k] = '0;
         if ((k < NUM_AXES) && perm_ok && (RANK_W'(k) < rank_ff)) begin
            out_dim[k]    = size_ff[perm[AX_W'(k)]];
            src_stride[k] = in_stride_ff[perm[AX_W'(k)]];
         end
      end
   end

   // Shared shift-add multiplier, one multiplier bit per cycle
   assign acc_in   = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign last_bit = (cnt_ff == CNT_W'(DIM_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_START;
         prod_we_ff <= 1'b0;
         ge_ff      <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         prod_we_ff <= 1'b0;
         if (csr_we) begin
            state_ff <= S_START;
         end else begin
            case (state_ff)
               S_IDLE: ;
               S_START: begin
                  ovf_ff <= 1'b0;
                  ge_ff  <= 1'b0;
                  if (rank_ok) begin
                     ax_ff <= AX_W'(rank_ff - RANK_W'(1));
                     in_stride_ff[AX_W'(rank_ff - RANK_W'(1))] <= ADDR_BITS'(1);
                     state_ff <= S_SLOAD;
                  end else begin
                     k_ff     <= '0;
                     state_ff <= S_PLOAD;
                  end
               end
               S_SLOAD: begin
                  mcand_ff  <= MW'(in_stride_ff[ax_ff]);
                  mplier_ff <= size_ff[ax_ff];
                  acc_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= S_SMUL;
               end
               S_SMUL: begin
                  acc_ff    <= acc_in;
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  cnt_ff    <= cnt_ff + CNT_W'(1);
                  if (last_bit) begin
                     // element count may reach 2^ADDR_BITS exactly, not beyond
                     if (ge_ff) begin
                        if (size_ff[ax_ff] > DIM_BITS'(1)) ovf_ff <= 1'b1;
                     end else if (acc_in > ADDR_POW) begin
                        ovf_ff <= 1'b1;
                     end else if (acc_in == ADDR_POW) begin
                        ge_ff <= 1'b1;
                     end
                     if (ax_ff != '0) begin
                        in_stride_ff[ax_ff - AX_W'(1)] <= acc_in[ADDR_BITS-1:0];
                        ax_ff    <= ax_ff - AX_W'(1);
                        state_ff <= S_SLOAD;
                     end else begin
                        k_ff     <= '0;
                        state_ff <= S_PLOAD;
                     end
                  end
               end
               S_PLOAD: begin
                  mcand_ff  <= MW'(src_stride[k_ff]);
                  mplier_ff <= coord[k_ff];
                  acc_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= S_PMUL;
               end
               S_PMUL: begin
                  acc_ff    <= acc_in;
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  cnt_ff    <= cnt_ff + CNT_W'(1);
                  if (last_bit) begin
                     prod_we_ff   <= 1'b1;
                     prod_idx_ff  <= k_ff;
                     prod_data_ff <= acc_in[ADDR_BITS-1:0];
                     if (k_ff == K_W'(MAX_RANK - 1)) begin
                        state_ff <= S_IDLE;
                     end else begin
                        k_ff     <= k_ff + K_W'(1);
                        state_ff <= S_PLOAD;
                     end
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign prod_we   = prod_we_ff;
   assign prod_idx  = prod_idx_ff;
   assign prod_data = prod_data_ff;

   assign status.busy       = (state_ff != S_IDLE) || prod_we_ff;
   assign status.cfg_err    = !perm_ok || (ovf_ff && !empty);
   assign status.empty      = empty;
   assign status.order_keep = order_keep;
   assign status.rank       = rank_ff;

endmodule
`default_nettype wire

@@ rtl/tta_walk.sv @@
// Output-coordinate odometer with incremental source offset and destination index.
`default_nettype none
module tta_walk #(
   parameter int MAX_RANK  = tta_pkg::DEF_MAX_RANK,
   parameter int DIM_BITS  = tta_pkg::DEF_DIM_BITS,
   parameter int ADDR_BITS = tta_pkg::DEF_ADDR_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic                       restart,
   input  tta_pkg::tta_status_type         status,
   input  wire logic [DIM_BITS-1:0]        out_dim [MAX_RANK],
   input  wire logic [ADDR_BITS-1:0]       src_stride [MAX_RANK],
   input  wire logic                       prod_we,
   input  wire logic [$clog2(MAX_RANK)-1:0] prod_idx,
   input  wire logic [ADDR_BITS-1:0]       prod_data,
   output logic [DIM_BITS-1:0]             coord [MAX_RANK],
   output logic                            res_valid_res,
   output logic [ADDR_BITS-1:0]            res_dest_index,
   output logic [ADDR_BITS-1:0]            res_source_offset,
   output logic                            res_last
);
   import tta_pkg::*;

   logic [DIM_BITS-1:0]  coord_ff [MAX_RANK];
   logic [ADDR_BITS-1:0] prod_ff [MAX_RANK];   // coord times stride, per axis
   logic [ADDR_BITS-1:0] offset_ff;
   logic [ADDR_BITS-1:0] dest_ff;
   logic                 exh_ff;

   logic                 act [MAX_RANK];
   logic [DIM_BITS-1:0]  adv_coord [MAX_RANK];
   logic [ADDR_BITS-1:0] adv_prod [MAX_RANK];
   logic [DIM_BITS-1:0]  nc [MAX_RANK];
   logic [ADDR_BITS-1:0] add_term;
   logic [ADDR_BITS-1:0] sub_term;
   logic [ADDR_BITS-1:0] adv_offset;
   logic                 found;
   logic                 ok;
   logic                 produce;
   logic                 last;

   always_comb begin
      found    = 1'b0;
      add_term = '0;
      sub_term = '0;
      for (int k = MAX_RANK - 1; k >= 0; k--) begin
         act[k]       = RANK_W'(k) < status.rank;
         adv_coord[k] = coord_ff[k];
         adv_prod[k]  = prod_ff[k];
         if (act[k] && !found) begin
            if (({1'b0, coord_ff[k]} + 1'b1) < {1'b0, out_dim[k]}) begin
               adv_coord[k] = coord_ff[k] + DIM_BITS'(1);
               adv_prod[k]  = prod_ff[k] + src_stride[k];
               add_term     = src_stride[k];
               found        = 1'b1;
            end else begin
               adv_coord[k] = '0;
               adv_prod[k]  = '0;
               sub_term     = sub_term + prod_ff[k];
            end
         end
      end
      adv_offset = offset_ff + add_term - sub_term;

      last = 1'b1;
      for (int k = 0; k < MAX_RANK; k++) begin
         nc[k] = restart ? '0 : adv_coord[k];
         if (act[k] && (({1'b0, nc[k]} + 1'b1) < {1'b0, out_dim[k]})) last = 1'b0;
      end

      ok      = !status.cfg_err && !status.empty;
      produce = ok && (restart || !exh_ff);
   end

   assign res_valid_res     = produce;
   assign res_dest_index    = (produce && !restart) ? dest_ff + ADDR_BITS'(1) : '0;
   assign res_source_offset = (produce && !restart) ? adv_offset : '0;
   assign res_last          = produce && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         dest_ff   <= '0;
         exh_ff    <= 1'b1;
         for (int k = 0; k < MAX_RANK; k++) begin
            coord_ff[k] <= '0;
            prod_ff[k]  <= '0;
         end
      end else if (prod_we) begin
         prod_ff[prod_idx] <= prod_data;
      end else if (step) begin
         if (produce) begin
            for (int k = 0; k < MAX_RANK; k++) begin
               coord_ff[k] <= nc[k];
               prod_ff[k]  <= restart ? '0 : adv_prod[k];
            end
            offset_ff <= restart ? '0 : adv_offset;
            dest_ff   <= restart ? '0 : dest_ff + ADDR_BITS'(1);
            exh_ff    <= last;
         end else if (restart || !exh_ff) begin
            exh_ff <= 1'b1;
         end
      end
   end

   assign coord = coord_ff;

endmodule
`default_nettype wire

@@ rtl/tta_rspbuf.sv @@
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module tta_rspbuf #(
   parameter int WIDTH = 68
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   logic             out_valid_ff;
   logic [WIDTH-1:0] out_data_ff;
   logic             skid_valid_ff;
   logic [WIDTH-1:0] skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
            if (in_valid) out_data_ff <= in_data;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= in_data;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

@@ rtl/tensor_transpose_address_generator.sv @@
// Top level of the N-dimensional transpose read-address generator.
`default_nettype none
// Walks the transposed tensor in row-major order and, per request transfer,
// returns the destination linear index and the source row-major offset of
// the element to read, with a last flag and the order-preserving and
// configuration-error flags. A request with req_restart high starts again
// at element 0; otherwise it advances one element. Throughput is one
// request per clock while req_ready is high. A result is registered in the
// result buffer's output register, or in its skid register while rsp_ready
// stalls the output; the two-entry result buffer lets a request transfer
// while an earlier result still waits. After reset and after every csr
// write the derive unit recomputes strides, the element-count overflow
// check and the per-axis offset terms on a shared shift-add multiplier,
// one multiplier bit per cycle; req_ready stays low for that pass.
// Configuration must be changed by the user only while no result is
// outstanding; the block itself does not enforce this.
module tensor_transpose_address_generator #(
   parameter int MAX_RANK  = tta_pkg::DEF_MAX_RANK,
   parameter int DIM_BITS  = tta_pkg::DEF_DIM_BITS,
   parameter int ADDR_BITS = tta_pkg::DEF_ADDR_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_restart,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid_res,
   output logic [ADDR_BITS-1:0]                rsp_dest_index,
   output logic [ADDR_BITS-1:0]                rsp_source_offset,
   output logic                                rsp_last,
   output logic                                rsp_order_preserving,
   output logic                                rsp_config_error,
   // configuration writes
   input  wire logic                           csr_we,
   input  wire logic [tta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tta_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tta_pkg::*;

   localparam int K_W    = $clog2(MAX_RANK);
   localparam int RESP_W = 4 + 2 * ADDR_BITS;

   tta_status_type       status;
   logic [DIM_BITS-1:0]  out_dim [MAX_RANK];
   logic [ADDR_BITS-1:0] src_stride [MAX_RANK];
   logic [DIM_BITS-1:0]  coord [MAX_RANK];
   logic                 prod_we;
   logic [K_W-1:0]       prod_idx;
   logic [ADDR_BITS-1:0] prod_data;

   logic                 step;
   logic                 buf_ready;
   logic                 res_valid_res;
   logic [ADDR_BITS-1:0] res_dest_index;
   logic [ADDR_BITS-1:0] res_source_offset;
   logic                 res_last;
   logic [RESP_W-1:0]    res_data;
   logic [RESP_W-1:0]    rsp_data;

   // Requests stall during the derive pass or when the result buffer is full
   assign req_ready = !status.busy && buf_ready;
   assign step      = req_valid && req_ready;

   tta_derive #(
      .MAX_RANK  (MAX_RANK),
      .DIM_BITS  (DIM_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_derive (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .coord      (coord),
      .status     (status),
      .out_dim    (out_dim),
      .src_stride (src_stride),
      .prod_we    (prod_we),
      .prod_idx   (prod_idx),
      .prod_data  (prod_data)
   );

   tta_walk #(
      .MAX_RANK  (MAX_RANK),
      .DIM_BITS  (DIM_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_walk (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .restart           (req_restart),
      .status            (status),
      .out_dim           (out_dim),
      .src_stride        (src_stride),
      .prod_we           (prod_we),
      .prod_idx          (prod_idx),
      .prod_data         (prod_data),
      .coord             (coord),
      .res_valid_res     (res_valid_res),
      .res_dest_index    (res_dest_index),
      .res_source_offset (res_source_offset),
      .res_last          (res_last)
   );

   // Flags are sampled with the result they belong to
   assign res_data = {res_valid_res, res_dest_index, res_source_offset, res_last,
                      status.order_keep, status.cfg_err};

   tta_rspbuf #(
      .WIDTH (RESP_W)
   ) u_rspbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step),
      .in_ready  (buf_ready),
      .in_data   (res_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign {rsp_valid_res, rsp_dest_index, rsp_source_offset, rsp_last,
           rsp_order_preserving, rsp_config_error} = rsp_data;

endmodule
`default_nettype wire
